// ----- hdl/round_robin_task_scheduler_defines.svh -----
// Assertion macros for the round-robin task scheduler.
// Assumes signals named clock and reset in the scope of use.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define RRTS_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("round_robin_task_scheduler: assertion failed");

// next-cycle implication
`define RRTS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("round_robin_task_scheduler: assertion failed");

`endif

// ----- hdl/rrts_pkg.sv -----
// Shared types and codes for the round-robin task scheduler.
// No dependencies.
package rrts_pkg;

   typedef enum logic [1:0] {
      ST_FREE,
      ST_RUNNABLE,
      ST_RUNNING,
      ST_SLEEPING
   } task_st_type;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_SLEEP,
      CMD_EXIT,
      CMD_ADMIT
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_OK,
      STAT_NO_CUR,
      STAT_NOT_FREE
   } status_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [31:0] sleep_ticks;
      logic [3:0]  slot;
   } req_type;

   typedef struct packed {
      logic [3:0]  running_slot;
      logic        running_valid;
      logic [31:0] tick_total;
      logic [1:0]  status_code;
   } rsp_type;

   // write side of the task table
   typedef struct packed {
      logic        st_we;
      task_st_type st_wdata;
      logic        cnt_we;
      logic [31:0] cnt_wdata;
   } tbl_wr_type;

   // sequencer status toward the top level
   typedef struct packed {
      logic       done;
      logic       running_valid;
      status_type status;
   } ctrl_stat_type;

endpackage

// ----- hdl/rrts_table.sv -----
// Task table: per-slot state and sleep count memories, one write and one read port.
// Depends on rrts_pkg.
module rrts_table #(
   parameter  int NUM_TASKS = 16,
   localparam int SW        = $clog2(NUM_TASKS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rrts_pkg::tbl_wr_type wr,
   input  logic [SW-1:0]        waddr,
   input  logic [SW-1:0]        raddr,
   output rrts_pkg::task_st_type st_rdata,
   output logic [31:0]          cnt_rdata
);
   import rrts_pkg::*;

   task_st_type          st_mem  [NUM_TASKS];
   logic [31:0]          cnt_mem [NUM_TASKS];
   logic [NUM_TASKS-1:0] vld_ff;
   logic                 vld_q_ff;
   task_st_type          st_q_ff;
   logic [31:0]          cnt_q_ff;

   always_ff @(posedge clock) begin
      if (wr.st_we) begin
         st_mem[waddr] <= wr.st_wdata;
      end
      if (wr.cnt_we) begin
         cnt_mem[waddr] <= wr.cnt_wdata;
      end
      st_q_ff  <= st_mem[raddr];
      cnt_q_ff <= cnt_mem[raddr];
   end

   // a slot never written reads as free
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff   <= '0;
         vld_q_ff <= 1'b0;
      end else begin
         if (wr.st_we) begin
            vld_ff[waddr] <= 1'b1;
         end
         vld_q_ff <= vld_ff[raddr];
      end
   end

   assign st_rdata  = vld_q_ff ? st_q_ff : ST_FREE;
   assign cnt_rdata = cnt_q_ff;

endmodule

// ----- hdl/rrts_ctrl.sv -----
// Sequencer: walks the task table one slot per cycle for the tick pass and
// the round-robin search, with a decrement/zero-test unit for the tick pass. Uses rrts_pkg.
module rrts_ctrl #(
   parameter  int NUM_TASKS = 16,
   localparam int SW        = $clog2(NUM_TASKS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  rrts_pkg::req_type       req,
   output logic                    busy,
   output rrts_pkg::tbl_wr_type    wr,
   output logic [SW-1:0]           waddr,
   output logic [SW-1:0]           raddr,
   input  rrts_pkg::task_st_type   st_rdata,
   input  logic [31:0]             cnt_rdata,
   output rrts_pkg::ctrl_stat_type stat,
   output logic [SW-1:0]           run_slot
);
   import rrts_pkg::*;

   localparam int CW = $clog2(NUM_TASKS + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_TICK,
      S_ADMIT_RD,
      S_ADMIT_CHK,
      S_SEARCH
   } state_type;

   state_type    state_ff, state_in;
   logic [SW-1:0] addr_ff, addr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [SW-1:0] rd_addr_ff, rd_addr_in;
   logic [SW-1:0] cur_ff, cur_in;
   logic          cur_vld_ff, cur_vld_in;
   status_type    status_ff, status_in;
   logic          slot_ok_ff, slot_ok_in;
   logic          done_ff, done_in;

   logic [SW+3:0] slot_wide;
   logic [31:0]   dec;
   logic          issue;
   logic          hit;

   function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] a);
      return (a == SW'(NUM_TASKS - 1)) ? '0 : a + 1'b1;
   endfunction

   assign slot_wide = (SW+4)'(req.slot);
   assign dec       = cnt_rdata - 32'd1;
   assign issue     = (cnt_ff != CW'(NUM_TASKS));
   assign hit       = rd_vld_ff && (st_rdata == ST_RUNNABLE);

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      cnt_in       = cnt_ff;
      rd_vld_in    = 1'b0;
      rd_addr_in   = addr_ff;
      cur_in       = cur_ff;
      cur_vld_in   = cur_vld_ff;
      status_in    = status_ff;
      slot_ok_in   = slot_ok_ff;
      done_in      = 1'b0;
      waddr        = cur_ff;
      wr.st_we     = 1'b0;
      wr.st_wdata  = ST_RUNNABLE;
      wr.cnt_we    = 1'b0;
      wr.cnt_wdata = '0;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               status_in = STAT_OK;
               cnt_in    = '0;
               // the running task gives up its slot state right at the transfer
               wr.st_we  = cur_vld_ff;
               case (cmd_type'(req.cmd))
                  CMD_TICK: begin
                     state_in = S_TICK;
                     addr_in  = '0;
                  end
                  CMD_SLEEP: begin
                     wr.st_wdata  = ST_SLEEPING;
                     wr.cnt_we    = cur_vld_ff;
                     wr.cnt_wdata = req.sleep_ticks;
                     if (!cur_vld_ff) begin
                        status_in = STAT_NO_CUR;
                     end
                     state_in = S_SEARCH;
                     addr_in  = next_slot(cur_ff);
                  end
                  CMD_EXIT: begin
                     wr.st_wdata = ST_FREE;
                     wr.cnt_we   = cur_vld_ff;
                     if (!cur_vld_ff) begin
                        status_in = STAT_NO_CUR;
                     end
                     state_in = S_SEARCH;
                     addr_in  = next_slot(cur_ff);
                  end
                  CMD_ADMIT: begin
                     state_in   = S_ADMIT_RD;
                     addr_in    = slot_wide[SW-1:0];
                     slot_ok_in = (slot_wide < (SW+4)'(NUM_TASKS));
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         S_TICK: begin
            if (issue) begin
               rd_vld_in = 1'b1;
               addr_in   = next_slot(addr_ff);
               cnt_in    = cnt_ff + 1'b1;
            end
            if (rd_vld_ff && (st_rdata == ST_SLEEPING)) begin
               waddr        = rd_addr_ff;
               wr.cnt_we    = 1'b1;
               wr.cnt_wdata = dec;
               wr.st_we     = (dec == 32'd0);
               wr.st_wdata  = ST_RUNNABLE;
            end
            // pass drained: last write is done before the search reads
            if (!issue && !rd_vld_ff) begin
               state_in = S_SEARCH;
               addr_in  = next_slot(cur_ff);
               cnt_in   = '0;
            end
         end

         S_ADMIT_RD: begin
            state_in = S_ADMIT_CHK;
         end

         S_ADMIT_CHK: begin
            if (slot_ok_ff && (st_rdata == ST_FREE)) begin
               waddr       = addr_ff;
               wr.st_we    = 1'b1;
               wr.st_wdata = ST_RUNNABLE;
            end else begin
               status_in = STAT_NOT_FREE;
            end
            state_in = S_SEARCH;
            addr_in  = next_slot(cur_ff);
            cnt_in   = '0;
         end

         S_SEARCH: begin
            if (hit) begin
               waddr       = rd_addr_ff;
               wr.st_we    = 1'b1;
               wr.st_wdata = ST_RUNNING;
               cur_in      = rd_addr_ff;
               cur_vld_in  = 1'b1;
               done_in     = 1'b1;
               state_in    = S_IDLE;
            end else if (issue) begin
               rd_vld_in = 1'b1;
               addr_in   = next_slot(addr_ff);
               cnt_in    = cnt_ff + 1'b1;
            end else if (!rd_vld_ff) begin
               // nothing runnable: keep cur_ff so the next search starts after it
               cur_vld_in = 1'b0;
               done_in    = 1'b1;
               state_in   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         addr_ff    <= '0;
         cnt_ff     <= '0;
         rd_vld_ff  <= 1'b0;
         cur_ff     <= '0;
         cur_vld_ff <= 1'b0;
         status_ff  <= STAT_OK;
         slot_ok_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         addr_ff    <= addr_in;
         cnt_ff     <= cnt_in;
         rd_vld_ff  <= rd_vld_in;
         cur_ff     <= cur_in;
         cur_vld_ff <= cur_vld_in;
         status_ff  <= status_in;
         slot_ok_ff <= slot_ok_in;
         done_ff    <= done_in;
      end
      rd_addr_ff <= rd_addr_in;
   end

   assign raddr              = addr_ff;
   assign busy               = (state_ff != S_IDLE);
   assign run_slot           = cur_ff;
   assign stat.done          = done_ff;
   assign stat.running_valid = cur_vld_ff;
   assign stat.status        = status_ff;

endmodule

// ----- hdl/round_robin_task_scheduler.sv -----
// Round-robin task scheduler with sleep timers: top level, tick counter, result port.
// Depends on rrts_pkg, rrts_table, rrts_ctrl and the assertion macro header.
//
//   channel   ports                        transfer when
//   request   start, busy, req_data        start && !busy at the clock edge
//   result    rsp_valid, rsp_data          rsp_valid high (one cycle only)
//
// A tick walks every slot and then searches, an admit reads and checks its slot first,
// and a sleep or exit goes straight to the search, which ends early at the first runnable slot.
// The task table has a single read port, so each pass reads one slot per cycle.
// busy stays high from the request transfer until the cycle the result shows.
// On reset, per-slot valid bits mark every slot free at once.
// The result is shown for one cycle and cannot be held off.
`include "round_robin_task_scheduler_defines.svh"

module round_robin_task_scheduler #(
   parameter int NUM_TASKS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rrts_pkg::req_type req_data,
   output logic              rsp_valid,
   output rrts_pkg::rsp_type rsp_data
);
   import rrts_pkg::*;

   localparam int SW = $clog2(NUM_TASKS);

   tbl_wr_type    wr;
   logic [SW-1:0] waddr;
   logic [SW-1:0] raddr;
   task_st_type   st_rdata;
   logic [31:0]   cnt_rdata;
   ctrl_stat_type stat;
   logic [SW-1:0] run_slot;
   logic [SW+3:0] run_wide;
   logic [31:0]   tick_ff, tick_in;

   rrts_table #(
      .NUM_TASKS (NUM_TASKS)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .wr        (wr),
      .waddr     (waddr),
      .raddr     (raddr),
      .st_rdata  (st_rdata),
      .cnt_rdata (cnt_rdata)
   );

   rrts_ctrl #(
      .NUM_TASKS (NUM_TASKS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req_data),
      .busy      (busy),
      .wr        (wr),
      .waddr     (waddr),
      .raddr     (raddr),
      .st_rdata  (st_rdata),
      .cnt_rdata (cnt_rdata),
      .stat      (stat),
      .run_slot  (run_slot)
   );

   always_comb begin
      tick_in = tick_ff;
      if (start && !busy && (cmd_type'(req_data.cmd) == CMD_TICK)) begin
         tick_in = tick_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else begin
         tick_ff <= tick_in;
      end
   end

   assign run_wide                = (SW+4)'(run_slot);
   assign rsp_valid               = stat.done;
   assign rsp_data.running_slot   = stat.running_valid ? run_wide[3:0] : 4'd0;
   assign rsp_data.running_valid  = stat.running_valid;
   assign rsp_data.tick_total     = tick_ff;
   assign rsp_data.status_code    = stat.status;

   `RRTS_ASSERT_IMPL(a_rsp_when_idle, rsp_valid, !busy)
   `RRTS_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
   `RRTS_ASSERT_IMPL(a_finish_gives_rsp, $fell(busy), rsp_valid)

endmodule
